/* rtl/core/daf_pkg.sv */
// Shared constants and conversion helpers for the decimal ASCII formatter.
package daf_pkg;

    localparam int VALUE_W         = 24;
    localparam int CHAR_W          = 6;
    localparam int IN_TDATA_W      = 24;
    localparam int OUT_TDATA_W     = 8;
    localparam int CONV_DIGITS     = 8;                    // digits a 24-bit value can need
    localparam int BCD_W           = CONV_DIGITS * 4;
    localparam int DD_W            = BCD_W + VALUE_W;      // BCD digits above the binary bits
    localparam int STEPS_PER_STAGE = 8;
    localparam int DD_STAGES       = VALUE_W / STEPS_PER_STAGE;
    localparam int DIGIT_CAP       = 10;
    localparam int MAX_DIGITS_DEF  = 7;
    localparam int MIN_DIGITS_DEF  = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Largest number of n decimal digits, n capped at DIGIT_CAP (elaboration only).
    function automatic longint nines_limit(input int n);
        longint lim;
        lim = 1;
        for (int i = 0; i < n && i < DIGIT_CAP; i++) begin
            lim = lim * 10;
        end
        return lim - 1;
    endfunction

    // One shift-and-add-3 step over the packed BCD and binary word.
    function automatic logic [DD_W-1:0] dabble_step(input logic [DD_W-1:0] w);
        logic [DD_W-1:0] t;
        t = w;
        for (int d = 0; d < CONV_DIGITS; d++) begin
            if (t[VALUE_W + d*4 +: 4] >= 4'd5) begin
                t[VALUE_W + d*4 +: 4] = t[VALUE_W + d*4 +: 4] + 4'd3;
            end
        end
        return {t[DD_W-2:0], 1'b0};
    endfunction

endpackage

/* rtl/core/decimal_ascii_formatter.sv */
// Decimal ASCII formatter: binary value in, one ASCII digit per output request out.
// The first character is valid once the value has passed the clamp stage, the three
// double-dabble stages of eight steps each, the width stage and the serializer.
// Each number is sent as max(MIN_DIGITS, significant digits) characters, up to MAX_DIGITS,
// one per cycle while i_m_tready is high; the next number loads as the last one is taken.
// Reset: synchronous, active low; clears all valid bits, data registers are not reset.
module decimal_ascii_formatter
    import daf_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int MIN_DIGITS = MIN_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [23:0] value
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [5:0] character, [7:6] zero
    output logic                   o_m_tlast,
    output logic                   o_m_tuser    // [0] saturated
);

    localparam int     NDIG   = MAX_DIGITS;
    localparam int     MINW   = (MIN_DIGITS > NDIG) ? NDIG : MIN_DIGITS;
    localparam int     DIG_W  = NDIG * 4;
    localparam int     EXT_W  = ((NDIG > CONV_DIGITS) ? NDIG : CONV_DIGITS) * 4;
    localparam int     CNT_W  = $clog2(NDIG + 1);
    localparam int     SH_W   = $clog2(DIG_W + 1);
    localparam longint LIM    = nines_limit(NDIG);
    localparam bit     SAT_EN = (LIM < (64'd1 << VALUE_W));
    localparam logic [VALUE_W-1:0] LIM_V = SAT_EN ? LIM[VALUE_W-1:0] : '1;
    localparam logic [CNT_W-1:0]   MINW_C = CNT_W'(MINW);

    // clamp stage (index 0) and double-dabble stages
    logic [DD_W-1:0] r_dd  [0:DD_STAGES];
    logic [DD_W-1:0] n_dd  [0:DD_STAGES];
    logic            r_v   [0:DD_STAGES];
    logic            r_sat [0:DD_STAGES];
    logic            rdy   [0:DD_STAGES];

    // width stage
    logic             r_l_valid;
    logic [DIG_W-1:0] r_l_digits;
    logic [CNT_W-1:0] r_l_cnt;
    logic             r_l_sat;
    logic [DIG_W-1:0] n_l_digits;
    logic [CNT_W-1:0] n_l_cnt;
    logic             l_ready;

    // serializer
    logic             r_s_valid;
    logic [DIG_W-1:0] r_s_digits;
    logic [CNT_W-1:0] r_s_cnt;
    logic             r_s_sat;
    logic             ser_load;
    logic             ser_done;
    logic [SH_W-1:0]  load_sh;
    logic [3:0]       top_digit;

    logic [VALUE_W-1:0] in_value;
    logic               in_sat;

    // clamp values beyond the widest printable number
    always_comb begin
        in_value = i_s_tdata[VALUE_W-1:0];
        in_sat   = SAT_EN && (in_value > LIM_V);
        if (in_sat) begin
            in_value = LIM_V;
        end
    end

    always_comb begin
        logic [DD_W-1:0] t;
        n_dd[0] = {{BCD_W{1'b0}}, in_value};
        for (int s = 1; s <= DD_STAGES; s++) begin
            t = r_dd[s-1];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                t = dabble_step(t);
            end
            n_dd[s] = t;
        end
    end

    // a stage takes new data when empty or when its content moves on
    always_comb begin
        rdy[DD_STAGES] = !r_v[DD_STAGES] || l_ready;
        for (int s = DD_STAGES - 1; s >= 0; s--) begin
            rdy[s] = !r_v[s] || rdy[s+1];
        end
    end

    assign o_s_tready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_dd[0]  <= n_dd[0];
            r_sat[0] <= in_sat;
        end
        for (int s = 1; s <= DD_STAGES; s++) begin
            if (rdy[s]) begin
                r_dd[s]  <= n_dd[s];
                r_sat[s] <= r_sat[s-1];
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= DD_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int s = 1; s <= DD_STAGES; s++) begin
                if (rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // count characters: significant digits, never below the minimum width
    always_comb begin
        logic [EXT_W-1:0] bcd_ext;
        logic [CNT_W-1:0] nz;
        bcd_ext    = EXT_W'(r_dd[DD_STAGES][DD_W-1 -: BCD_W]);
        n_l_digits = bcd_ext[DIG_W-1:0];
        nz         = '0;
        for (int k = 0; k < NDIG; k++) begin
            if (n_l_digits[k*4 +: 4] != 4'd0) begin
                nz = CNT_W'(k + 1);
            end
        end
        n_l_cnt = (nz < MINW_C) ? MINW_C : nz;
    end

    assign ser_done = r_s_valid && i_m_tready && (r_s_cnt == CNT_W'(1));
    assign ser_load = r_l_valid && (!r_s_valid || ser_done);
    assign l_ready  = !r_l_valid || ser_load;
    assign load_sh  = SH_W'((NDIG - int'(r_l_cnt)) * 4);

    always_ff @(posedge i_clk) begin
        if (l_ready) begin
            r_l_digits <= n_l_digits;
            r_l_cnt    <= n_l_cnt;
            r_l_sat    <= r_sat[DD_STAGES];
        end
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (l_ready) begin
            r_l_valid <= r_v[DD_STAGES];
        end
    end

    // serializer: first character sits in the top digit, shift up after each request
    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_s_digits <= r_l_digits << load_sh;
            r_s_cnt    <= r_l_cnt;
            r_s_sat    <= r_l_sat;
        end else if (r_s_valid && i_m_tready) begin
            r_s_digits <= r_s_digits << 4;
            r_s_cnt    <= r_s_cnt - CNT_W'(1);
        end
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (ser_load) begin
            r_s_valid <= 1'b1;
        end else if (ser_done) begin
            r_s_valid <= 1'b0;
        end
    end

    assign top_digit  = r_s_digits[DIG_W-1 -: 4];
    assign o_m_tvalid = r_s_valid;
    assign o_m_tdata  = OUT_TDATA_W'(ASCII_ZERO + CHAR_W'(top_digit));
    assign o_m_tlast  = (r_s_cnt == CNT_W'(1));
    assign o_m_tuser  = r_s_sat;

    a_ser_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_s_cnt != '0) && (r_s_cnt <= CNT_W'(NDIG)))
        else $error("serializer count out of range");

    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (top_digit <= 4'd9))
        else $error("non-decimal digit at output");

    a_min_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l_valid |-> (r_l_cnt >= MINW_C))
        else $error("character count below minimum width");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_sat[0]) |-> (r_dd[0][VALUE_W-1:0] == LIM_V))
        else $error("saturated value not clamped");

endmodule

/* bench/decimal_ascii_formatter_tb.sv */
// Self-checking bench: drives values into the formatter and checks each ASCII digit it sends.
module decimal_ascii_formatter_tb;
    import daf_pkg::*;

    localparam int MAX_DIG     = MAX_DIGITS_DEF;
    localparam int MIN_DIG     = MIN_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 32;
    localparam int PHASE_ITEMS = 80;

    // idling phases
    localparam int PH_FREE     = 0;
    localparam int PH_TX_IDLE  = 1;
    localparam int PH_RX_STALL = 2;
    localparam int PH_BOTH     = 3;

    typedef struct {
        logic [VALUE_W-1:0] value;
        int                 phase;
        bit                 drain;
    } t_number_req;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              sat;
        int                phase;
    } t_ascii_digit;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;      // [23:0] value
    int                     s_phase = 0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [5:0] character, [7:6] zero
    logic                   m_tlast;
    logic                   m_tuser;           // [0] saturated

    t_number_req  number_q[$];
    t_ascii_digit digit_q[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;

    decimal_ascii_formatter #(
        .MAX_DIGITS(MAX_DIG),
        .MIN_DIGITS(MIN_DIG)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .o_m_tuser (m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint pow10(input int k);
        longint p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Split a value into its decimal characters and queue them in send order.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value, input int phase);
        logic [3:0]   digs [0:DIGIT_CAP-1];
        longint       v;
        logic         sat;
        int           first;
        int           start;
        t_ascii_digit d;
        v   = longint'(value);
        sat = 1'b0;
        if (v > pow10(MAX_DIG) - 1) begin
            v   = pow10(MAX_DIG) - 1;
            sat = 1'b1;
        end
        for (int i = MAX_DIG - 1; i >= 0; i--) begin
            digs[i] = 4'(v % 10);
            v       = v / 10;
        end
        first = MAX_DIG;
        for (int i = MAX_DIG - 1; i >= 0; i--) begin
            if (digs[i] != 4'd0) first = i;
        end
        start = MAX_DIG - MIN_DIG;
        if (first < start) start = first;
        for (int i = start; i < MAX_DIG; i++) begin
            d.ch    = ASCII_ZERO + CHAR_W'(digs[i]);
            d.last  = (i == MAX_DIG - 1);
            d.sat   = sat;
            d.phase = phase;
            digit_q.push_back(d);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int     k;
        longint lo;
        case ($urandom_range(9))
            0: return VALUE_W'($urandom_range(999));
            1: return VALUE_W'($urandom_range(9999));
            2: begin
                k  = $urandom_range(6, 3);
                lo = pow10(k);
                return VALUE_W'(lo + $urandom_range(int'(pow10(k + 1) - lo - 1)));
            end
            3: begin
                // hover around a power of ten
                k = $urandom_range(7, 1);
                return VALUE_W'(pow10(k) + $urandom_range(2) - 1);
            end
            4: return VALUE_W'($urandom_range(16777215, 10000000));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void add_number(input logic [VALUE_W-1:0] value, input int phase,
                                       input bit drain);
        t_number_req r;
        r.value = value;
        r.phase = phase;
        r.drain = drain;
        number_q.push_back(r);
    endfunction

    // Sender: one request per accepted value, expected digits queued on acceptance.
    always @(posedge i_clk) begin : drive_proc
        t_number_req r;
        bit          fire;
        bit          idle;
        int          pct;
        fire = s_tvalid && s_tready;
        if (fire) predict_digits(s_tdata[VALUE_W-1:0], s_phase);
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || fire) begin
            idle = 1'b1;
            if (number_q.size() > 0) begin
                r   = number_q[0];
                pct = (r.phase == PH_TX_IDLE) ? 71 : (r.phase == PH_BOTH) ? 18 : 0;
                // hold until the block has sent everything owed
                if (!(r.drain && digit_q.size() != 0) && $urandom_range(99) >= pct) begin
                    idle = 1'b0;
                end
            end
            if (idle) begin
                s_tvalid <= 1'b0;
            end else begin
                void'(number_q.pop_front());
                s_tvalid <= 1'b1;
                s_tdata  <= r.value;
                s_phase  <= r.phase;
            end
        end
    end

    // Receiver: compare each accepted character with the oldest expectation.
    always @(posedge i_clk) begin : monitor_proc
        t_ascii_digit want;
        int           pct;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digit_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected character: tdata %0d last %0b sat %0b",
                             m_tdata, m_tlast, m_tuser);
                end
            end else begin
                want = digit_q.pop_front();
                if ({m_tdata, m_tlast, m_tuser} !== {2'b00, want.ch, want.last, want.sat}) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: tdata %0d last %0b sat %0b, expected %0d %0b %0b",
                                 m_tdata, m_tlast, m_tuser, want.ch, want.last, want.sat);
                    end
                end
            end
        end
        pct = 0;
        if (digit_q.size() > 0) begin
            pct = (digit_q[0].phase == PH_RX_STALL) ? 71 :
                  (digit_q[0].phase == PH_BOTH) ? 18 : 0;
        end
        m_tready <= ($urandom_range(99) >= pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : main_proc
        longint p;
        // powers of ten and the values just below them, then assorted corners
        for (int k = 0; k <= MAX_DIG; k++) begin
            p = pow10(k);
            if (k > 0) add_number(VALUE_W'(p - 1), PH_FREE, 1'b0);
            add_number(VALUE_W'(p), PH_FREE, 1'b0);
        end
        add_number(24'd0, PH_FREE, 1'b0);
        add_number(24'd10000001, PH_FREE, 1'b0);
        add_number(24'hFFFFFF, PH_FREE, 1'b0);
        add_number(24'hAAAAAA, PH_FREE, 1'b0);
        add_number(24'h555555, PH_FREE, 1'b0);
        add_number(24'd1234567, PH_FREE, 1'b0);
        add_number(24'd42, PH_FREE, 1'b0);
        add_number(24'h800000, PH_FREE, 1'b0);

        for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                add_number(pick_value(), ph, n == 0 || $urandom_range(39) == 0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (number_q.size() != 0 || s_tvalid || digit_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && digit_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
